// ===== design/ffha_pkg.sv =====
`default_nettype none
package ffha_pkg;

    localparam int MAX_BLOCKS   = 64;
    localparam int HEADER_BYTES = 24;
    localparam int PAGE_BYTES   = 4096;
    localparam int MIN_PAYLOAD  = 16;
    localparam int GUARD_BYTES  = 4;
    localparam int IDX_W        = $clog2(MAX_BLOCKS + 1);
    localparam int SLOT_W       = $clog2(MAX_BLOCKS);
    localparam logic [IDX_W-1:0] NONE_IDX = IDX_W'(MAX_BLOCKS);

    typedef enum logic [2:0] {
        ST_OK         = 3'd0,
        ST_ZERO       = 3'd1,
        ST_NO_SPACE   = 3'd2,
        ST_TABLE_FULL = 3'd3,
        ST_INVALID    = 3'd4
    } t_status;

    localparam logic REQ_ALLOC = 1'b0;

    typedef struct packed {
        logic        req_type;
        logic [23:0] req_size;
        logic [31:0] free_address;
    } t_in_item;

    typedef struct packed {
        logic [31:0] grant_address;
        logic [2:0]  status;
        logic [31:0] alloc_total;
        logic [31:0] free_total;
        logic [31:0] live_count;
        logic [31:0] live_bytes;
        logic [31:0] peak_count;
        logic [31:0] peak_live_bytes;
        logic [31:0] leak_count;
    } t_out_item;

    typedef enum logic [4:0] {
        CMD_NONE,
        CMD_LOAD,
        CMD_ST_ZERO,
        CMD_ST_NOSPACE,
        CMD_ST_FULL,
        CMD_ST_INVALID,
        CMD_RD_CUR,
        CMD_ADVANCE,
        CMD_TAKE,
        CMD_SPLIT_NEW,
        CMD_SPLIT_PREV,
        CMD_SPLIT_OWN,
        CMD_G_END,
        CMD_APPEND,
        CMD_APP_LINK,
        CMD_RD_K,
        CMD_K_INC,
        CMD_F_MARK,
        CMD_RD_NX,
        CMD_F_MNX,
        CMD_F_N2,
        CMD_F_N3,
        CMD_RD_PV,
        CMD_F_MPV,
        CMD_F_P2,
        CMD_F_P3,
        CMD_EMIT
    } t_cmd;

    typedef struct packed {
        logic is_alloc;
        logic req_zero;
        logic cur_none;
        logic fit;
        logic split_ok;
        logic next_ok;
        logic prev_ok;
        logic link_ok;
        logic rd_free;
        logic hit;
        logic k_done;
        logic no_space;
        logic no_slot;
        logic out_free;
    } t_dp_status;

endpackage
`default_nettype wire

// ===== design/first_fit_heap_allocator_unit.sv =====
// First-fit heap allocator. An allocate walks the block list one block at a time,
// reading each block through the single read port of the block table, and tries to grow
// the heap when no free block fits. A free scans the table slot by slot (up to 64 slots)
// for a matching payload address and then merges the block with its free neighbors.
// A new request is taken once the previous result has been placed in the output register.
`default_nettype none
module first_fit_heap_allocator_unit
    import ffha_pkg::*;
(
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_in_valid,
    output logic        o_in_stall,
    input  t_in_item    i_in_data,
    output logic        o_out_valid,
    input  wire         i_out_stall,
    output t_out_item   o_out_data,
    input  wire         psel,
    input  wire         penable,
    input  wire         pwrite,
    input  wire  [2:0]  paddr,
    input  wire  [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    t_cmd        cmd;
    t_dp_status  st;
    logic [31:0] heap_base;
    logic [24:0] heap_size;
    logic        cfg_we;

    assign pready = 1'b1;
    assign cfg_we = psel && penable && pwrite;
    assign prdata = paddr[2] ? 32'(heap_size) : heap_base;

    ffha_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_st       (st),
        .o_in_stall (o_in_stall),
        .o_cmd      (cmd)
    );

    ffha_dpath u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .i_in_data   (i_in_data),
        .i_out_stall (i_out_stall),
        .i_cfg_we    (cfg_we),
        .i_cfg_sel   (paddr[2]),
        .i_cfg_data  (pwdata),
        .o_heap_base (heap_base),
        .o_heap_size (heap_size),
        .o_st        (st),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data)
    );

    a_live_matches: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_data.live_count ==
                         o_out_data.alloc_total - o_out_data.free_total))
        else $error("live count disagrees with allocation and free totals");

    a_peak_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_data.peak_count >= o_out_data.live_count))
        else $error("peak count below live count");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("request taken while previous one still in work");

endmodule
`default_nettype wire

// ===== design/ffha_ctrl.sv =====
`default_nettype none
module ffha_ctrl
    import ffha_pkg::*;
(
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_in_valid,
    input  t_dp_status  i_st,
    output logic        o_in_stall,
    output t_cmd        o_cmd
);

    typedef enum logic [4:0] {
        S_IDLE, S_DISP, S_A_RD, S_A_CHK, S_SPLIT_NXP, S_SPLIT_OWN,
        S_G_END, S_G_CHK, S_APP_LINK, S_F_RD, S_F_CHK, S_F_NRD, S_F_NCHK,
        S_F_N2, S_F_N3, S_F_PRD, S_F_PCHK, S_F_P2, S_F_P3, S_OUT
    } t_state;

    t_state r_state, n_state;

    always_comb begin
        n_state = r_state;
        o_cmd   = CMD_NONE;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd   = CMD_LOAD;
                    n_state = S_DISP;
                end
            end
            S_DISP: begin
                if (!i_st.is_alloc) begin
                    n_state = S_F_RD;
                end else if (i_st.req_zero) begin
                    o_cmd   = CMD_ST_ZERO;
                    n_state = S_OUT;
                end else begin
                    n_state = S_A_RD;
                end
            end
            S_A_RD: begin
                if (i_st.cur_none) begin
                    n_state = S_G_END;
                end else begin
                    o_cmd   = CMD_RD_CUR;
                    n_state = S_A_CHK;
                end
            end
            S_A_CHK: begin
                if (i_st.fit && i_st.split_ok) begin
                    o_cmd   = CMD_SPLIT_NEW;
                    n_state = S_SPLIT_NXP;
                end else if (i_st.fit) begin
                    o_cmd   = CMD_TAKE;
                    n_state = S_OUT;
                end else begin
                    o_cmd   = CMD_ADVANCE;
                    n_state = S_A_RD;
                end
            end
            S_SPLIT_NXP: begin
                if (i_st.next_ok) begin
                    o_cmd = CMD_SPLIT_PREV;
                end
                n_state = S_SPLIT_OWN;
            end
            S_SPLIT_OWN: begin
                o_cmd   = CMD_SPLIT_OWN;
                n_state = S_OUT;
            end
            S_G_END: begin
                o_cmd   = CMD_G_END;
                n_state = S_G_CHK;
            end
            S_G_CHK: begin
                if (i_st.no_space) begin
                    o_cmd   = CMD_ST_NOSPACE;
                    n_state = S_OUT;
                end else if (i_st.no_slot) begin
                    o_cmd   = CMD_ST_FULL;
                    n_state = S_OUT;
                end else begin
                    o_cmd   = CMD_APPEND;
                    n_state = S_APP_LINK;
                end
            end
            S_APP_LINK: begin
                if (i_st.link_ok) begin
                    o_cmd = CMD_APP_LINK;
                end
                n_state = S_OUT;
            end
            S_F_RD: begin
                if (i_st.k_done) begin
                    o_cmd   = CMD_ST_INVALID;
                    n_state = S_OUT;
                end else begin
                    o_cmd   = CMD_RD_K;
                    n_state = S_F_CHK;
                end
            end
            S_F_CHK: begin
                if (i_st.hit) begin
                    o_cmd   = CMD_F_MARK;
                    n_state = S_F_NRD;
                end else begin
                    o_cmd   = CMD_K_INC;
                    n_state = S_F_RD;
                end
            end
            S_F_NRD: begin
                if (i_st.next_ok) begin
                    o_cmd   = CMD_RD_NX;
                    n_state = S_F_NCHK;
                end else begin
                    n_state = S_F_PRD;
                end
            end
            S_F_NCHK: begin
                if (i_st.rd_free) begin
                    o_cmd   = CMD_F_MNX;
                    n_state = S_F_N2;
                end else begin
                    n_state = S_F_PRD;
                end
            end
            S_F_N2: begin
                o_cmd   = CMD_F_N2;
                n_state = S_F_N3;
            end
            S_F_N3: begin
                if (i_st.next_ok) begin
                    o_cmd = CMD_F_N3;
                end
                n_state = S_F_PRD;
            end
            S_F_PRD: begin
                if (i_st.prev_ok) begin
                    o_cmd   = CMD_RD_PV;
                    n_state = S_F_PCHK;
                end else begin
                    n_state = S_OUT;
                end
            end
            S_F_PCHK: begin
                if (i_st.rd_free) begin
                    o_cmd   = CMD_F_MPV;
                    n_state = S_F_P2;
                end else begin
                    n_state = S_OUT;
                end
            end
            S_F_P2: begin
                o_cmd   = CMD_F_P2;
                n_state = S_F_P3;
            end
            S_F_P3: begin
                if (i_st.next_ok) begin
                    o_cmd = CMD_F_P3;
                end
                n_state = S_OUT;
            end
            S_OUT: begin
                if (i_st.out_free) begin
                    o_cmd   = CMD_EMIT;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_in_stall = (r_state != S_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule
`default_nettype wire

// ===== design/ffha_dpath.sv =====
`default_nettype none
module ffha_dpath
    import ffha_pkg::*;
(
    input  wire          i_clk,
    input  wire          i_rst_n,
    input  t_cmd         i_cmd,
    input  t_in_item     i_in_data,
    input  wire          i_out_stall,
    input  wire          i_cfg_we,
    input  wire          i_cfg_sel,
    input  wire  [31:0]  i_cfg_data,
    output logic [31:0]  o_heap_base,
    output logic [24:0]  o_heap_size,
    output t_dp_status   o_st,
    output logic         o_out_valid,
    output t_out_item    o_out_data
);

    localparam logic [31:0] HDR32 = 32'(HEADER_BYTES);

    logic [31:0] mem_start [MAX_BLOCKS];
    logic [24:0] mem_size  [MAX_BLOCKS];
    logic [23:0] mem_req   [MAX_BLOCKS];
    logic        mem_free  [MAX_BLOCKS];
    logic [IDX_W-1:0] mem_next [MAX_BLOCKS];
    logic [IDX_W-1:0] mem_prev [MAX_BLOCKS];

    logic [31:0] r_heap_base;
    logic [24:0] r_heap_size;
    logic [MAX_BLOCKS-1:0] r_valid;
    logic [IDX_W-1:0] r_head, r_tail, r_cur, r_k, r_i, r_sidx;
    logic [31:0] r_top;
    logic [31:0] r_cnt_alloc, r_cnt_free, r_cnt_live, r_cnt_bytes, r_peak_c, r_peak_b;
    logic        r_req_type;
    logic [23:0] r_req_size;
    logic [31:0] r_free_addr;
    logic [24:0] r_need;
    logic [33:0] r_end;
    logic [31:0] r_e_start;
    logic [24:0] r_e_size;
    logic [IDX_W-1:0] r_e_next, r_e_prev;
    logic [31:0] r_grant;
    logic [2:0]  r_status;
    logic        r_out_valid;
    t_out_item   r_out;

    logic [31:0] r_rd_start;
    logic [24:0] r_rd_size;
    logic [23:0] r_rd_req;
    logic        r_rd_free;
    logic [IDX_W-1:0] r_rd_next, r_rd_prev;

    logic             rd_en;
    logic [SLOT_W-1:0] rd_addr;
    logic [SLOT_W-1:0] w_addr;
    logic we_start, we_size, we_req, we_free, we_next, we_prev;
    logic [31:0] w_start;
    logic [24:0] w_size;
    logic [23:0] w_req;
    logic        w_free;
    logic [IDX_W-1:0] w_next, w_prev;

    logic [SLOT_W-1:0] slot;
    logic              slot_found;
    logic [31:0] rbase;
    logic [32:0] limit_sum;
    logic [33:0] limit;
    logic [33:0] end_raw, end_rnd;
    logic [31:0] a_live, a_bytes;
    logic [31:0] cfg_base;
    logic [24:0] n_need;

    always_comb begin
        slot       = '0;
        slot_found = 1'b0;
        for (int j = MAX_BLOCKS - 1; j >= 0; j--) begin
            if (!r_valid[j]) begin
                slot       = SLOT_W'(j);
                slot_found = 1'b1;
            end
        end
    end

    assign rbase     = (r_heap_base + 32'd15) & ~32'd15;
    assign limit_sum = {1'b0, rbase} + 33'(r_heap_size);
    assign limit     = (limit_sum > 33'h0FFFFFFFF) ? 34'h0FFFFFFFF : {1'b0, limit_sum};
    assign end_raw   = 34'(r_top) + 34'(HEADER_BYTES) + 34'(r_need);
    assign end_rnd   = (end_raw + 34'(PAGE_BYTES - 1)) & ~34'(PAGE_BYTES - 1);
    assign a_live    = r_cnt_live + 32'd1;
    assign a_bytes   = r_cnt_bytes + 32'(r_req_size);
    assign cfg_base  = i_cfg_sel ? r_heap_base : i_cfg_data;
    assign n_need    = (25'(i_in_data.req_size) + 25'(GUARD_BYTES + 15)) & ~25'd15;

    always_comb begin
        o_st.is_alloc = (r_req_type == REQ_ALLOC);
        o_st.req_zero = (r_req_size == '0);
        o_st.cur_none = (r_cur >= NONE_IDX);
        o_st.fit      = r_rd_free && (r_rd_size >= r_need);
        o_st.split_ok = slot_found &&
                        (26'(r_rd_size) >= 26'(r_need) + 26'(HEADER_BYTES + MIN_PAYLOAD));
        o_st.next_ok  = (r_e_next < NONE_IDX);
        o_st.prev_ok  = (r_e_prev < NONE_IDX);
        o_st.link_ok  = (r_i < NONE_IDX);
        o_st.rd_free  = r_rd_free;
        o_st.hit      = r_valid[r_k[SLOT_W-1:0]] && !r_rd_free &&
                        ((r_rd_start + HDR32) == r_free_addr);
        o_st.k_done   = (r_k >= NONE_IDX);
        o_st.no_space = (r_end > limit);
        o_st.no_slot  = !slot_found;
        o_st.out_free = !r_out_valid || !i_out_stall;
    end

    always_comb begin
        rd_en    = 1'b0;
        rd_addr  = '0;
        w_addr   = '0;
        we_start = 1'b0;
        we_size  = 1'b0;
        we_req   = 1'b0;
        we_free  = 1'b0;
        we_next  = 1'b0;
        we_prev  = 1'b0;
        w_start  = '0;
        w_size   = '0;
        w_req    = '0;
        w_free   = 1'b0;
        w_next   = '0;
        w_prev   = '0;
        case (i_cmd)
            CMD_RD_CUR: begin
                rd_en   = 1'b1;
                rd_addr = r_cur[SLOT_W-1:0];
            end
            CMD_RD_K: begin
                rd_en   = 1'b1;
                rd_addr = r_k[SLOT_W-1:0];
            end
            CMD_RD_NX: begin
                rd_en   = 1'b1;
                rd_addr = r_e_next[SLOT_W-1:0];
            end
            CMD_RD_PV: begin
                rd_en   = 1'b1;
                rd_addr = r_e_prev[SLOT_W-1:0];
            end
            CMD_TAKE: begin
                w_addr  = r_cur[SLOT_W-1:0];
                we_free = 1'b1;
                we_req  = 1'b1;
                w_req   = r_req_size;
            end
            CMD_SPLIT_NEW: begin
                w_addr   = slot;
                we_start = 1'b1;
                we_size  = 1'b1;
                we_req   = 1'b1;
                we_free  = 1'b1;
                we_next  = 1'b1;
                we_prev  = 1'b1;
                w_start  = r_rd_start + HDR32 + 32'(r_need);
                w_size   = r_rd_size - r_need - 25'(HEADER_BYTES);
                w_free   = 1'b1;
                w_next   = r_rd_next;
                w_prev   = r_cur;
            end
            CMD_SPLIT_PREV: begin
                w_addr  = r_e_next[SLOT_W-1:0];
                we_prev = 1'b1;
                w_prev  = r_sidx;
            end
            CMD_SPLIT_OWN: begin
                w_addr  = r_i[SLOT_W-1:0];
                we_size = 1'b1;
                we_next = 1'b1;
                we_free = 1'b1;
                we_req  = 1'b1;
                w_size  = r_need;
                w_next  = r_sidx;
                w_req   = r_req_size;
            end
            CMD_APPEND: begin
                w_addr   = slot;
                we_start = 1'b1;
                we_size  = 1'b1;
                we_req   = 1'b1;
                we_free  = 1'b1;
                we_next  = 1'b1;
                we_prev  = 1'b1;
                w_start  = r_top;
                w_size   = r_need;
                w_req    = r_req_size;
                w_next   = NONE_IDX;
                w_prev   = r_tail;
            end
            CMD_APP_LINK: begin
                w_addr  = r_i[SLOT_W-1:0];
                we_next = 1'b1;
                w_next  = r_sidx;
            end
            CMD_F_MARK: begin
                w_addr  = r_k[SLOT_W-1:0];
                we_free = 1'b1;
                w_free  = 1'b1;
            end
            CMD_F_MNX: begin
                w_addr  = r_i[SLOT_W-1:0];
                we_size = 1'b1;
                w_size  = r_e_size + 25'(HEADER_BYTES) + r_rd_size;
            end
            CMD_F_N2: begin
                w_addr  = r_i[SLOT_W-1:0];
                we_next = 1'b1;
                w_next  = r_e_next;
            end
            CMD_F_N3: begin
                w_addr  = r_e_next[SLOT_W-1:0];
                we_prev = 1'b1;
                w_prev  = r_i;
            end
            CMD_F_MPV: begin
                w_addr  = r_e_prev[SLOT_W-1:0];
                we_size = 1'b1;
                w_size  = r_rd_size + 25'(HEADER_BYTES) + r_e_size;
            end
            CMD_F_P2: begin
                w_addr  = r_e_prev[SLOT_W-1:0];
                we_next = 1'b1;
                w_next  = r_e_next;
            end
            CMD_F_P3: begin
                w_addr  = r_e_next[SLOT_W-1:0];
                we_prev = 1'b1;
                w_prev  = r_e_prev;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (we_start) mem_start[w_addr] <= w_start;
        if (we_size)  mem_size[w_addr]  <= w_size;
        if (we_req)   mem_req[w_addr]   <= w_req;
        if (we_free)  mem_free[w_addr]  <= w_free;
        if (we_next)  mem_next[w_addr]  <= w_next;
        if (we_prev)  mem_prev[w_addr]  <= w_prev;
        if (rd_en) begin
            r_rd_start <= mem_start[rd_addr];
            r_rd_size  <= mem_size[rd_addr];
            r_rd_req   <= mem_req[rd_addr];
            r_rd_free  <= mem_free[rd_addr];
            r_rd_next  <= mem_next[rd_addr];
            r_rd_prev  <= mem_prev[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        case (i_cmd)
            CMD_LOAD: begin
                r_req_type  <= i_in_data.req_type;
                r_req_size  <= i_in_data.req_size;
                r_free_addr <= i_in_data.free_address;
                r_need      <= n_need;
                r_grant     <= '0;
                r_status    <= ST_OK;
            end
            CMD_ST_ZERO:    r_status <= ST_ZERO;
            CMD_ST_NOSPACE: r_status <= ST_NO_SPACE;
            CMD_ST_FULL:    r_status <= ST_TABLE_FULL;
            CMD_ST_INVALID: r_status <= ST_INVALID;
            CMD_TAKE:       r_grant  <= r_rd_start + HDR32;
            CMD_SPLIT_NEW: begin
                r_sidx    <= IDX_W'(slot);
                r_i       <= r_cur;
                r_e_start <= r_rd_start;
                r_e_next  <= r_rd_next;
            end
            CMD_SPLIT_OWN:  r_grant <= r_e_start + HDR32;
            CMD_G_END:      r_end   <= end_rnd;
            CMD_APPEND: begin
                r_sidx  <= IDX_W'(slot);
                r_i     <= r_tail;
                r_grant <= r_top + HDR32;
            end
            CMD_F_MARK: begin
                r_i      <= r_k;
                r_e_size <= r_rd_size;
                r_e_next <= r_rd_next;
                r_e_prev <= r_rd_prev;
            end
            CMD_F_MNX: begin
                r_e_size <= r_e_size + 25'(HEADER_BYTES) + r_rd_size;
                r_e_next <= r_rd_next;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_heap_base <= '0;
            r_heap_size <= '0;
            r_valid     <= '0;
            r_head      <= NONE_IDX;
            r_tail      <= NONE_IDX;
            r_top       <= '0;
            r_cur       <= NONE_IDX;
            r_k         <= '0;
            r_cnt_alloc <= '0;
            r_cnt_free  <= '0;
            r_cnt_live  <= '0;
            r_cnt_bytes <= '0;
            r_peak_c    <= '0;
            r_peak_b    <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_sel) begin
                    r_heap_size <= i_cfg_data[24:0];
                end else begin
                    r_heap_base <= i_cfg_data;
                end
                r_valid <= '0;
                r_head  <= NONE_IDX;
                r_tail  <= NONE_IDX;
                r_top   <= (cfg_base + 32'd15) & ~32'd15;
            end
            if (i_cmd == CMD_EMIT) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            case (i_cmd)
                CMD_LOAD: begin
                    r_cur <= r_head;
                    r_k   <= '0;
                end
                CMD_ADVANCE: r_cur <= r_rd_next;
                CMD_K_INC:   r_k   <= r_k + IDX_W'(1);
                CMD_TAKE, CMD_SPLIT_OWN, CMD_APPEND: begin
                    r_cnt_alloc <= r_cnt_alloc + 32'd1;
                    r_cnt_live  <= a_live;
                    r_cnt_bytes <= a_bytes;
                    if (a_live > r_peak_c) r_peak_c <= a_live;
                    if (a_bytes > r_peak_b) r_peak_b <= a_bytes;
                    if (i_cmd == CMD_SPLIT_OWN && r_e_next >= NONE_IDX) begin
                        r_tail <= r_sidx;
                    end
                    if (i_cmd == CMD_APPEND) begin
                        r_valid[slot] <= 1'b1;
                        r_tail        <= IDX_W'(slot);
                        r_top         <= r_end[31:0];
                        if (r_head >= NONE_IDX) begin
                            r_head <= IDX_W'(slot);
                        end
                    end
                end
                CMD_SPLIT_NEW: r_valid[slot] <= 1'b1;
                CMD_F_MARK: begin
                    r_cnt_free  <= r_cnt_free + 32'd1;
                    r_cnt_live  <= r_cnt_live - 32'd1;
                    r_cnt_bytes <= r_cnt_bytes - 32'(r_rd_req);
                end
                CMD_F_MNX: begin
                    r_valid[r_e_next[SLOT_W-1:0]] <= 1'b0;
                    if (r_tail == r_e_next) r_tail <= r_i;
                end
                CMD_F_MPV: begin
                    r_valid[r_i[SLOT_W-1:0]] <= 1'b0;
                    if (r_tail == r_i) r_tail <= r_e_prev;
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd == CMD_EMIT) begin
            r_out.grant_address   <= r_grant;
            r_out.status          <= r_status;
            r_out.alloc_total     <= r_cnt_alloc;
            r_out.free_total      <= r_cnt_free;
            r_out.live_count      <= r_cnt_live;
            r_out.live_bytes      <= r_cnt_bytes;
            r_out.peak_count      <= r_peak_c;
            r_out.peak_live_bytes <= r_peak_b;
            r_out.leak_count      <= r_cnt_alloc - r_cnt_free;
        end
    end

    assign o_heap_base = r_heap_base;
    assign o_heap_size = r_heap_size;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule
`default_nettype wire

// ===== tb/first_fit_heap_allocator_unit_tb.sv =====
`timescale 1ns / 1ps
module first_fit_heap_allocator_unit_tb;
    import ffha_pkg::*;

    localparam int IDLE_LIMIT = 20000;
    localparam int HOLD_CYCLES = 500;
    localparam logic REQ_FREE = 1'b1;
    localparam logic [2:0] ADDR_BASE = 3'd0;
    localparam logic [2:0] ADDR_SIZE = 3'd4;

    typedef struct {
        bit          after_cfg;
        logic        kind;
        logic [23:0] size;
        logic [31:0] addr;
        bit          typed;
        t_status     st;
        logic [31:0] grant;
    } t_row;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        in_valid = 1'b0;
    t_in_item    in_data = '0;
    logic        out_stall = 1'b0;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [2:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    wire         o_in_stall;
    wire         o_out_valid;
    t_out_item   o_out_data;
    wire  [31:0] prdata;
    wire         pready;

    bit          row_typed = 1'b0;
    t_status     row_st = ST_OK;
    logic [31:0] row_grant = '0;

    bit          hold_req = 1'b0;
    int          mismatches = 0;
    int          idle_cycles = 0;
    t_out_item   pending_results[$];
    logic [31:0] live_grants[$];
    logic [31:0] last_freed = '0;

    logic [31:0] heap_base_r;
    logic [24:0] heap_size_r;
    logic [31:0] blk_start [MAX_BLOCKS];
    logic [31:0] blk_size  [MAX_BLOCKS];
    logic [23:0] blk_req   [MAX_BLOCKS];
    bit          blk_free  [MAX_BLOCKS];
    int          blk_next  [MAX_BLOCKS];
    int          blk_prev  [MAX_BLOCKS];
    bit          slot_used [MAX_BLOCKS];
    int          first_blk;
    logic [31:0] top_addr;
    logic [31:0] n_alloc, n_free, n_live, n_bytes, pk_count, pk_bytes;

    first_fit_heap_allocator_unit dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (out_stall),
        .o_out_data  (o_out_data),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    function automatic logic [31:0] base_aligned();
        return (heap_base_r + 32'd15) & ~32'd15;
    endfunction

    function automatic void heap_clear();
        foreach (slot_used[k]) slot_used[k] = 1'b0;
        first_blk = MAX_BLOCKS;
        top_addr = base_aligned();
        live_grants.delete();
    endfunction

    function automatic int free_slot();
        for (int k = 0; k < MAX_BLOCKS; k++) begin
            if (!slot_used[k]) return k;
        end
        return MAX_BLOCKS;
    endfunction

    function automatic void drop_blk(int n);
        int p, x;
        p = blk_prev[n];
        x = blk_next[n];
        if (p < MAX_BLOCKS) blk_next[p] = x;
        else first_blk = x;
        if (x < MAX_BLOCKS) blk_prev[x] = p;
        slot_used[n] = 1'b0;
    endfunction

    function automatic void count_grant(logic [23:0] req);
        n_alloc++;
        n_live++;
        n_bytes += 32'(req);
        if (n_live > pk_count) pk_count = n_live;
        if (n_bytes > pk_bytes) pk_bytes = n_bytes;
    endfunction

    function automatic t_status grant_block(logic [23:0] req, output logic [31:0] grant);
        logic [31:0] need;
        longint unsigned fence, lim;
        int i, s, steps, last;
        grant = '0;
        if (req == 0) return ST_ZERO;
        need = (32'(req) + GUARD_BYTES + 32'd15) & ~32'd15;
        if (need < MIN_PAYLOAD) need = MIN_PAYLOAD;
        i = first_blk;
        steps = 0;
        while (i < MAX_BLOCKS && steps < MAX_BLOCKS) begin
            if (blk_free[i] && blk_size[i] >= need) begin
                if (blk_size[i] >= need + HEADER_BYTES + MIN_PAYLOAD) begin
                    s = free_slot();
                    if (s < MAX_BLOCKS) begin
                        slot_used[s] = 1'b1;
                        blk_start[s] = blk_start[i] + HEADER_BYTES + need;
                        blk_size[s] = (blk_size[i] - need - HEADER_BYTES) & 32'h1FF_FFFF;
                        blk_req[s] = '0;
                        blk_free[s] = 1'b1;
                        blk_next[s] = blk_next[i];
                        blk_prev[s] = i;
                        if (blk_next[i] < MAX_BLOCKS) blk_prev[blk_next[i]] = s;
                        blk_next[i] = s;
                        blk_size[i] = need;
                    end
                end
                blk_free[i] = 1'b0;
                blk_req[i] = req;
                grant = blk_start[i] + HEADER_BYTES;
                count_grant(req);
                return ST_OK;
            end
            i = blk_next[i];
            steps++;
        end
        fence = longint'(top_addr) + HEADER_BYTES + longint'(need);
        fence = (fence + PAGE_BYTES - 1) / PAGE_BYTES * PAGE_BYTES;
        lim = longint'(base_aligned()) + longint'(heap_size_r);
        if (lim > 64'hFFFF_FFFF) lim = 64'hFFFF_FFFF;
        if (fence > lim) return ST_NO_SPACE;
        s = free_slot();
        if (s >= MAX_BLOCKS) return ST_TABLE_FULL;
        slot_used[s] = 1'b1;
        blk_start[s] = top_addr;
        blk_size[s] = need;
        blk_req[s] = req;
        blk_free[s] = 1'b0;
        blk_next[s] = MAX_BLOCKS;
        blk_prev[s] = MAX_BLOCKS;
        if (first_blk >= MAX_BLOCKS) begin
            first_blk = s;
        end else begin
            last = first_blk;
            steps = 0;
            while (blk_next[last] < MAX_BLOCKS && steps < MAX_BLOCKS) begin
                last = blk_next[last];
                steps++;
            end
            blk_next[last] = s;
            blk_prev[s] = last;
        end
        top_addr = fence[31:0];
        grant = blk_start[s] + HEADER_BYTES;
        count_grant(req);
        return ST_OK;
    endfunction

    function automatic t_status release_block(logic [31:0] addr);
        int i, nx, pv;
        i = MAX_BLOCKS;
        for (int k = 0; k < MAX_BLOCKS; k++) begin
            if (slot_used[k] && !blk_free[k] && blk_start[k] + HEADER_BYTES == addr) begin
                i = k;
                break;
            end
        end
        if (i >= MAX_BLOCKS) return ST_INVALID;
        n_free++;
        n_live--;
        n_bytes -= 32'(blk_req[i]);
        blk_free[i] = 1'b1;
        nx = blk_next[i];
        if (nx < MAX_BLOCKS && blk_free[nx]) begin
            blk_size[i] = (blk_size[i] + HEADER_BYTES + blk_size[nx]) & 32'h1FF_FFFF;
            drop_blk(nx);
        end
        pv = blk_prev[i];
        if (pv < MAX_BLOCKS && blk_free[pv]) begin
            blk_size[pv] = (blk_size[pv] + HEADER_BYTES + blk_size[i]) & 32'h1FF_FFFF;
            drop_blk(i);
        end
        return ST_OK;
    endfunction

    function automatic t_out_item heap_result(t_in_item it);
        t_out_item r;
        logic [31:0] grant;
        t_status st;
        grant = '0;
        if (it.req_type == REQ_ALLOC) begin
            st = grant_block(it.req_size, grant);
            if (st == ST_OK) live_grants.push_back(grant);
        end else begin
            st = release_block(it.free_address);
            if (st == ST_OK) begin
                last_freed = it.free_address;
                foreach (live_grants[k]) begin
                    if (live_grants[k] == it.free_address) begin
                        live_grants.delete(k);
                        break;
                    end
                end
            end
        end
        r.grant_address = grant;
        r.status = st;
        r.alloc_total = n_alloc;
        r.free_total = n_free;
        r.live_count = n_live;
        r.live_bytes = n_bytes;
        r.peak_count = pk_count;
        r.peak_live_bytes = pk_bytes;
        r.leak_count = n_alloc - n_free;
        return r;
    endfunction

    always @(posedge i_clk) begin
        t_out_item want;
        if (i_rst_n) begin
            if ((in_valid && !o_in_stall) || (o_out_valid && !out_stall)) idle_cycles <= 0;
            else idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("status: fail");
                $finish;
            end else begin
                if (in_valid && !o_in_stall) begin
                    want = heap_result(in_data);
                    if (row_typed) begin
                        want.status = row_st;
                        want.grant_address = row_grant;
                    end
                    pending_results.push_back(want);
                end
                if (o_out_valid && !out_stall) begin
                    if (pending_results.size() == 0) begin
                        mismatches++;
                        if (mismatches <= 10) $display("unexpected beat %p", o_out_data);
                    end else begin
                        want = pending_results.pop_front();
                        if (o_out_data !== want) begin
                            mismatches++;
                            if (mismatches <= 10)
                                $display("mismatch\n  expected %p\n  actual   %p", want, o_out_data);
                        end
                    end
                end
            end
        end
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(99);
        if (r < 60) return 0;
        if (r < 90) return $urandom_range(3, 1);
        return $urandom_range(40, 10);
    endfunction

    initial begin
        int r, n;
        wait (i_rst_n);
        forever begin
            if (hold_req) begin
                hold_req = 1'b0;
                out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge i_clk);
            end
            r = $urandom_range(99);
            if (r < 50) begin
                out_stall <= 1'b0;
                n = $urandom_range(30, 1);
            end else begin
                out_stall <= 1'b1;
                n = (r < 90) ? $urandom_range(3, 1) : $urandom_range(40, 10);
            end
            repeat (n) @(posedge i_clk);
        end
    end

    task automatic reg_write(logic [2:0] addr, logic [31:0] data);
        psel <= 1'b1;
        pwrite <= 1'b1;
        penable <= 1'b0;
        paddr <= addr;
        pwdata <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        if (addr == ADDR_BASE) heap_base_r = data;
        else heap_size_r = data[24:0];
        heap_clear();
    endtask

    task automatic send_req(t_in_item it, bit typed, t_status st, logic [31:0] grant);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_valid <= 1'b1;
        in_data <= it;
        row_typed <= typed;
        row_st <= st;
        row_grant <= grant;
        do @(posedge i_clk); while (o_in_stall !== 1'b0);
    endtask

    task automatic drain_results();
        in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
    endtask

    task automatic set_heap(logic [31:0] base, logic [31:0] size);
        drain_results();
        reg_write(ADDR_BASE, base);
        reg_write(ADDR_SIZE, size);
    endtask

    function automatic t_in_item random_req(int alloc_pct);
        t_in_item it;
        int r;
        it.req_type = ($urandom_range(99) < alloc_pct) ? REQ_ALLOC : REQ_FREE;
        r = $urandom_range(99);
        if (r < 1) it.req_size = '0;
        else if (r < 80) it.req_size = 24'($urandom_range(256, 1));
        else if (r < 96) it.req_size = 24'($urandom_range(20000, 257));
        else it.req_size = 24'($urandom);
        r = $urandom_range(99);
        if (r < 80 && live_grants.size() > 0)
            it.free_address = live_grants[$urandom_range(live_grants.size() - 1)];
        else if (r < 90) it.free_address = last_freed;
        else it.free_address = $urandom;
        return it;
    endfunction

    t_row dir_rows[] = '{
        '{0, REQ_ALLOC, 24'd0,        32'd0,        1, ST_ZERO,     32'd0},
        '{0, REQ_ALLOC, 24'd1,        32'd0,        1, ST_NO_SPACE, 32'd0},
        '{0, REQ_FREE,  24'd0,        32'd0,        1, ST_INVALID,  32'd0},
        '{1, REQ_ALLOC, 24'd1,        32'd0,        1, ST_OK,       32'h1018},
        '{1, REQ_ALLOC, 24'd100,      32'd0,        1, ST_OK,       32'h2018},
        '{1, REQ_FREE,  24'd0,        32'h1018,     1, ST_OK,       32'd0},
        '{1, REQ_FREE,  24'd0,        32'h1018,     1, ST_INVALID,  32'd0},
        '{1, REQ_ALLOC, 24'd8,        32'd0,        1, ST_OK,       32'h1018},
        '{1, REQ_ALLOC, 24'hFF_FFFF,  32'd0,        1, ST_NO_SPACE, 32'd0},
        '{1, REQ_FREE,  24'd0,        32'hFFFF_FFFF, 1, ST_INVALID, 32'd0},
        '{1, REQ_FREE,  24'hFF_FFFF,  32'h2018,     1, ST_OK,       32'd0},
        '{1, REQ_ALLOC, 24'd3000,     32'd0,        1, ST_OK,       32'h3018},
        '{1, REQ_FREE,  24'd0,        32'h3018,     0, ST_OK,       32'd0},
        '{1, REQ_ALLOC, 24'd40,       32'd0,        0, ST_OK,       32'd0},
        '{1, REQ_ALLOC, 24'd500,      32'd0,        0, ST_OK,       32'd0},
        '{1, REQ_ALLOC, 24'd12,       32'd0,        0, ST_OK,       32'd0},
        '{1, REQ_FREE,  24'd0,        32'h2018,     0, ST_OK,       32'd0},
        '{1, REQ_FREE,  24'd0,        32'h1018,     0, ST_OK,       32'd0},
        '{1, REQ_ALLOC, 24'd60,       32'd0,        0, ST_OK,       32'd0},
        '{1, REQ_ALLOC, 24'd5000,     32'd0,        0, ST_OK,       32'd0}
    };

    logic [31:0] phase_base[5] = '{32'h0000_1000, 32'hFFF0_0007, 32'h0000_0000,
                                   32'hFFFF_FFF0, 32'h0000_1000};
    logic [31:0] phase_size[5] = '{32'h0100_0000, 32'h0100_0000, 32'h0000_6000,
                                   32'h0100_0000, 32'h0010_0000};
    int phase_items[5] = '{250, 230, 150, 60, 240};
    int phase_alloc[5] = '{70, 60, 55, 50, 50};

    initial begin
        bit cfg_done;
        t_in_item it;
        n_alloc = '0;
        n_free = '0;
        n_live = '0;
        n_bytes = '0;
        pk_count = '0;
        pk_bytes = '0;
        heap_base_r = '0;
        heap_size_r = '0;
        heap_clear();
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        cfg_done = 1'b0;
        foreach (dir_rows[k]) begin
            if (dir_rows[k].after_cfg && !cfg_done) begin
                set_heap(32'h1000, 32'h10_0000);
                cfg_done = 1'b1;
            end
            it.req_type = dir_rows[k].kind;
            it.req_size = dir_rows[k].size;
            it.free_address = dir_rows[k].addr;
            send_req(it, dir_rows[k].typed, dir_rows[k].st, dir_rows[k].grant);
        end
        for (int p = 0; p < 5; p++) begin
            set_heap(phase_base[p], phase_size[p]);
            for (int k = 0; k < phase_items[p]; k++) begin
                if (p == 0 && k == 30) hold_req = 1'b1;
                send_req(random_req(phase_alloc[p]), 1'b0, ST_OK, '0);
            end
        end
        drain_results();
        repeat (200) @(posedge i_clk);
        if (mismatches == 0 && pending_results.size() == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
